FILE: design/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRIO_W       = 16;
  localparam int NAME_W       = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [PRIO_W-1:0] priority_req;
    logic [NAME_W-1:0] process_name;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] out_priority;
    logic [NAME_W-1:0] out_name;
    logic              last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    cmp;
    logic    insert;
    logic    pop;
    logic    rotate;
    logic    search_cmp;
    logic    scan_clr;
    logic    set_res;
    status_t res_code;
    logic    out_load;
    logic    out_sel_head;
    logic    out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/spq_ctrl.sv
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_INSERT = 7'b0000100,
    S_POP    = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_LIST   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.res_code = spq_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == spq_pkg::OP_INSERT) begin
          if (stat.full) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = spq_pkg::ST_FULL;
            state_next   = S_RESP;
          end else begin
            cmd.cmp    = 1'b1;
            state_next = S_INSERT;
          end
        end else if (stat.empty) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = spq_pkg::ST_EMPTY;
          state_next   = S_RESP;
        end else if (stat.op == spq_pkg::OP_POP) begin
          state_next = S_POP;
        end else if (stat.op == spq_pkg::OP_SEARCH) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = spq_pkg::ST_NOTFOUND;
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_LIST;
        end
      end
      S_INSERT: begin
        cmd.insert   = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = spq_pkg::ST_OK;
        state_next   = S_RESP;
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel_head = 1'b1;
          cmd.out_last     = 1'b1;
          cmd.pop          = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_SCAN: begin
        // A full rotation visits every entry and leaves the order unchanged.
        cmd.rotate     = 1'b1;
        cmd.search_cmp = 1'b1;
        if (stat.scan_last) begin
          state_next = S_RESP;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel_head = 1'b1;
          cmd.out_last     = stat.scan_last;
          cmd.rotate       = 1'b1;
          if (stat.scan_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state is not one-hot");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !cmd.out_load)
    else $error("result loaded while accepting a request");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_SCAN && stat.scan_last) |=> state == S_RESP)
    else $error("search did not finish with a response");

endmodule

FILE: design/spq_datapath.sv
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::in_t   in_data,
  input  spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t stat,
  input  logic           out_ready,
  output logic           out_valid,
  output spq_pkg::out_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::in_t                 req;
  logic [spq_pkg::PRIO_W-1:0]   cell_prio [CAPACITY];
  logic [spq_pkg::NAME_W-1:0]   cell_name [CAPACITY];
  logic [spq_pkg::PRIO_W-1:0]   prev_prio [CAPACITY];
  logic [spq_pkg::NAME_W-1:0]   prev_name [CAPACITY];
  logic [spq_pkg::PRIO_W-1:0]   nxt_prio  [CAPACITY];
  logic [spq_pkg::NAME_W-1:0]   nxt_name  [CAPACITY];
  logic [CAPACITY-1:0]          gt_now;
  logic [CAPACITY-1:0]          gt;
  logic [CAPACITY-1:0]          gt_prev;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_m1;
  logic [CNT_W-1:0]             scan;
  spq_pkg::status_t             res_status;
  logic [spq_pkg::PRIO_W-1:0]   res_prio;
  logic [spq_pkg::NAME_W-1:0]   res_name;
  logic                         out_free;

  assign count_m1 = count - CNT_W'(1);
  assign out_free = !out_valid || out_ready;
  assign gt_prev  = {gt[CAPACITY-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
    end
  end

  // Entries past the insertion point have a strictly greater priority.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt_now[i] = (count > CNT_W'(i)) && (cell_prio[i] > req.priority_req);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      gt <= gt_now;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

    if (i == 0) begin : g_first
      assign prev_prio[i] = req.priority_req;
      assign prev_name[i] = req.process_name;
    end else begin : g_rest
      assign prev_prio[i] = cell_prio[i-1];
      assign prev_name[i] = cell_name[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nxt_prio[i] = cell_prio[i];
      assign nxt_name[i] = cell_name[i];
    end else begin : g_body
      assign nxt_prio[i] = cell_prio[i+1];
      assign nxt_name[i] = cell_name[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (gt_prev[i]) begin
          cell_prio[i] <= prev_prio[i];
          cell_name[i] <= prev_name[i];
        end else if (gt[i] || IDX == count) begin
          cell_prio[i] <= req.priority_req;
          cell_name[i] <= req.process_name;
        end
      end else if (cmd.pop) begin
        cell_prio[i] <= nxt_prio[i];
        cell_name[i] <= nxt_name[i];
      end else if (cmd.rotate) begin
        if (IDX == count_m1) begin
          cell_prio[i] <= cell_prio[0];
          cell_name[i] <= cell_name[0];
        end else if (IDX < count_m1) begin
          cell_prio[i] <= nxt_prio[i];
          cell_name[i] <= nxt_name[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop) begin
      count <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.rotate) begin
      scan <= scan + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_prio   <= '0;
      res_name   <= '0;
    end else if (cmd.search_cmp && res_status == spq_pkg::ST_NOTFOUND &&
                 cell_prio[0] == req.priority_req) begin
      res_status <= spq_pkg::ST_OK;
      res_prio   <= cell_prio[0];
      res_name   <= cell_name[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel_head) begin
        out_data.status       <= spq_pkg::ST_OK;
        out_data.out_priority <= cell_prio[0];
        out_data.out_name     <= cell_name[0];
      end else begin
        out_data.status       <= res_status;
        out_data.out_priority <= res_prio;
        out_data.out_name     <= res_name;
      end
      out_data.last <= cmd.out_last;
    end
  end

  assign stat.op        = req.operation;
  assign stat.full      = (count == CNT_W'(CAPACITY));
  assign stat.empty     = (count == '0);
  assign stat.scan_last = (scan == count_m1);
  assign stat.out_free  = out_free;

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");
  assert property (@(posedge clk) disable iff (rst)
      cmd.insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the queue by one");
  assert property (@(posedge clk) disable iff (rst)
      cmd.pop |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not shrink the queue by one");
  assert property (@(posedge clk) disable iff (rst) (cmd.rotate || cmd.pop) |-> count != '0)
    else $error("rotate or pop on an empty queue");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |-> out_free)
    else $error("result register overwritten before it was taken");

endmodule

FILE: design/sorted_priority_queue.sv
// Pop goes through decode and the pop state, insert through decode, insert and response,
// search through decode, a rotation over every stored entry and response, and list sends
// registered beats one per cycle while out_ready is high; full or empty replies use decode
// and response. One request at a time; a new request is taken once the previous one has
// loaded its final beat, set by the controller sequence and the single head-of-list read
// port. Synchronous active-high reset empties the queue and drops any pending result beat.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::out_t out_data
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
